// ----- rtl/gca_pkg.sv -----
// Shared constants and helpers for the great-circle arc and azimuth core.
// Holds fixed-point widths, the CORDIC gain, the Q4.30 product and the
// elaboration-time arctangent table generator. No dependencies.
`default_nettype none
package gca_pkg;

  // Q4.30 values in the datapath, wider internal word for vectoring CORDIC
  localparam int QW = 34;
  localparam int VW = 36;
  localparam int SQ_STEPS = 31;

  localparam logic signed [QW-1:0] CGAIN = 34'sh026DD3B6A;
  localparam logic signed [QW-1:0] Q_ONE = 34'sh040000000;
  localparam logic signed [2*QW-1:0] MUL_RND = 68'sh20000000;
  localparam logic [63:0] INV_TWO_PI = 64'h28BE60DB9391054A;

  // Configuration register indexes
  localparam logic CFG_ORIGIN_LAT = 1'b0;
  localparam logic CFG_ORIGIN_LON = 1'b1;

  // Q4.30 product, rounded half up
  function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    p = p + MUL_RND;
    return p[QW+29:30];
  endfunction

  // Series term divided by the odd number 2k+1
  function automatic logic [63:0] odd_div(input logic [63:0] n, input int k);
    case (k)
      0:  return n;
      1:  return n / 64'd3;
      2:  return n / 64'd5;
      3:  return n / 64'd7;
      4:  return n / 64'd9;
      5:  return n / 64'd11;
      6:  return n / 64'd13;
      7:  return n / 64'd15;
      8:  return n / 64'd17;
      9:  return n / 64'd19;
      10: return n / 64'd21;
      11: return n / 64'd23;
      12: return n / 64'd25;
      13: return n / 64'd27;
      14: return n / 64'd29;
      15: return n / 64'd31;
      16: return n / 64'd33;
      17: return n / 64'd35;
      18: return n / 64'd37;
      19: return n / 64'd39;
      20: return n / 64'd41;
      21: return n / 64'd43;
      22: return n / 64'd45;
      23: return n / 64'd47;
      24: return n / 64'd49;
      25: return n / 64'd51;
      26: return n / 64'd53;
      27: return n / 64'd55;
      28: return n / 64'd57;
      29: return n / 64'd59;
      30: return n / 64'd61;
      31: return n / 64'd63;
      default: return 64'd0;
    endcase
  endfunction

  // atan(2^-i) as a 64-bit turn fraction, from the arctangent series
  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0] s;
    logic [63:0] t;
    logic [127:0] p;
    int e;
    int k;
    s = 64'd0;
    if (i == 0) begin
      return 64'h2000_0000_0000_0000;
    end
    for (k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e < 64) begin
        t = odd_div(64'd1 << (64 - e), k);
        if (k[0]) s = s - t;
        else s = s + t;
      end
    end
    p = {64'd0, s} * {64'd0, INV_TWO_PI};
    return p[127:64];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/great_circle_arc_azimuth_core.sv -----
// Great-circle arc, azimuth and back azimuth from a configured origin.
// Uses gca_pkg, gca_delay, gca_sincos, gca_sqrt and gca_atan2.
//
// Usage: write the origin latitude (index 0) and longitude (index 1) on the
// cfg channel while the pipeline is empty; cfg_ready is always high.
// Each request on the in_ stream carries one destination point, and one
// result request leaves on the out_ stream per input, in order.
// A result passes in series through the angle register, a CORDIC pipeline,
// four product stages, the 31-stage square root, a second CORDIC pipeline
// and the output register.
// Throughput is one point per cycle while the receiver takes the results.
// Reset clears the origin to zero and empties the pipeline.
// When the receiver stalls, every stage holds; in_tready drops only while
// the output register holds a result that is not taken.
// Degenerate points (coincident or antipodal) set out_tuser and return zero
// azimuths; the arc is still reported.
`default_nettype none
module great_circle_arc_azimuth_core #(
  parameter int ANGLE_BITS    = 32,
  parameter int CORDIC_STAGES = 30
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        in_tvalid,
  output logic                                             in_tready,
  // point_latitude, point_longitude
  input  wire logic [((2*ANGLE_BITS+7)/8)*8-1:0]           in_tdata,
  input  wire logic                                        in_tlast,
  output logic                                             out_tvalid,
  input  wire logic                                        out_tready,
  // arc_angle, azimuth, back_azimuth
  output logic [((3*ANGLE_BITS+7)/8)*8-1:0]                out_tdata,
  // degenerate
  output logic                                             out_tuser,
  output logic                                             out_tlast,
  input  wire logic                                        cfg_valid,
  output logic                                             cfg_ready,
  input  wire logic                                        cfg_index,
  input  wire logic [ANGLE_BITS-1:0]                       cfg_data
);
  import gca_pkg::*;

  localparam int AB     = ANGLE_BITS;
  localparam int OUT_DW = ((3*AB+7)/8)*8;
  localparam int PAD    = 64 - AB;
  localparam int LSC    = CORDIC_STAGES + 2;
  localparam int LA     = CORDIC_STAGES + 2;
  localparam int TS     = 1 + LSC;
  localparam int TC     = TS + 3;
  localparam int TG     = TC + 1 + SQ_STEPS;
  localparam int TA     = TG + LA;
  localparam int LAT    = TA + 1;
  localparam int D_CGC  = TG - TC;
  localparam int D_AZ   = TA - (TC + 2 + LA);

  localparam int ANG_LAT_O = 0;
  localparam int ANG_LAT_D = 1;
  localparam int ANG_HALF  = 2;
  localparam int ANG_DIFF  = 3;
  localparam int ANG_SUM   = 4;
  localparam int ANG_DLON  = 5;
  localparam int N_ANG     = 6;

  localparam logic [60:0] SQ_ONE = 61'd1 << 60;
  localparam logic signed [QW:0] CLAMP_HI = 35'sh040000000;
  localparam logic signed [QW:0] CLAMP_LO = -35'sh040000000;

  function automatic logic [AB-1:0] to_out(input logic [63:0] t);
    logic [63:0] s;
    s = t + (64'd1 << (63 - AB));
    return s[63 -: AB];
  endfunction

  logic                 en;
  logic [LAT-1:0]       vld_r;
  logic [AB-1:0]        org_lat_r, org_lon_r;
  logic [AB-1:0]        in_lat, in_lon;
  logic [63:0]          ang_r [N_ANG];
  logic signed [QW-1:0] sc_sin [N_ANG];
  logic signed [QW-1:0] sc_cos [N_ANG];

  logic signed [QW-1:0] h_r, cdiff_r, csum_r, p1_r, p2_r, cgc_r;
  logic signed [QW:0]   cgc_raw;
  logic signed [QW-1:0] sO_c, cO_c, sD_c, cD_c, sdl_c;
  logic signed [QW-1:0] y1_r, x1_r, y2_r, x2_r, cO_r, cD_r;
  logic signed [QW-1:0] ya_r, xa_r, yb_r, xb_r;
  logic signed [2*QW-1:0] sq_full;
  logic [60:0]          sq_r;
  logic [30:0]          sg_root;
  logic signed [QW-1:0] sgc, cgc_d;
  logic [63:0]          gc_t, az_t, baz_t, az_d, baz_d;
  logic                 deg_d, last_d;
  logic [3*AB-1:0]      pay_r;
  logic                 deg_r, last_r;

  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;
  assign in_lat    = in_tdata[AB-1:0];
  assign in_lon    = in_tdata[2*AB-1:AB];

  // Origin registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_lat_r <= '0;
      org_lon_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ORIGIN_LAT: org_lat_r <= cfg_data;
        CFG_ORIGIN_LON: org_lon_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // Stage 1: form the six turn angles
  always_ff @(posedge clk) begin
    if (en) begin
      ang_r[ANG_LAT_O] <= {org_lat_r, {PAD{1'b0}}};
      ang_r[ANG_LAT_D] <= {in_lat, {PAD{1'b0}}};
      ang_r[ANG_HALF]  <= {1'b0, AB'(org_lon_r - in_lon), {(PAD-1){1'b0}}};
      ang_r[ANG_DIFF]  <= {AB'(in_lat - org_lat_r), {PAD{1'b0}}};
      ang_r[ANG_SUM]   <= {AB'(in_lat + org_lat_r), {PAD{1'b0}}};
      ang_r[ANG_DLON]  <= {AB'(in_lon - org_lon_r), {PAD{1'b0}}};
    end
  end

  for (genvar g = 0; g < N_ANG; g++) begin : g_sc
    gca_sincos #(.STAGES(CORDIC_STAGES)) u_sc (
      .clk  (clk),
      .en   (en),
      .angle(ang_r[g]),
      .sin_o(sc_sin[g]),
      .cos_o(sc_cos[g])
    );
  end

  // Haversine cosine of the arc, clamped to +-1
  assign cgc_raw = (QW+1)'(p1_r) - (QW+1)'(p2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      h_r     <= mulq(sc_sin[ANG_HALF], sc_sin[ANG_HALF]);
      cdiff_r <= sc_cos[ANG_DIFF];
      csum_r  <= sc_cos[ANG_SUM];
      p1_r    <= mulq(cdiff_r, Q_ONE - h_r);
      p2_r    <= mulq(csum_r, h_r);
      if (cgc_raw > CLAMP_HI) cgc_r <= Q_ONE;
      else if (cgc_raw < CLAMP_LO) cgc_r <= -Q_ONE;
      else cgc_r <= cgc_raw[QW-1:0];
    end
  end

  gca_delay #(.W(5*QW), .D(3)) u_side (
    .clk(clk),
    .en (en),
    .d  ({sc_sin[ANG_LAT_O], sc_cos[ANG_LAT_O], sc_sin[ANG_LAT_D],
          sc_cos[ANG_LAT_D], sc_sin[ANG_DLON]}),
    .q  ({sO_c, cO_c, sD_c, cD_c, sdl_c})
  );

  assign sq_full = cgc_r * cgc_r;

  // Azimuth numerators and denominators
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_full[60:0];
      y1_r <= mulq(cD_c, sdl_c);
      x1_r <= sD_c - mulq(sO_c, cgc_r);
      y2_r <= -mulq(cO_c, sdl_c);
      x2_r <= sO_c - mulq(sD_c, cgc_r);
      cO_r <= cO_c;
      cD_r <= cD_c;
      // scale by the cosine magnitude, flip the other side on a negative one
      ya_r <= mulq(y1_r, cO_r[QW-1] ? -cO_r : cO_r);
      xa_r <= cO_r[QW-1] ? -x1_r : x1_r;
      yb_r <= mulq(y2_r, cD_r[QW-1] ? -cD_r : cD_r);
      xb_r <= cD_r[QW-1] ? -x2_r : x2_r;
    end
  end

  gca_sqrt u_sqrt (
    .clk     (clk),
    .en      (en),
    .radicand(SQ_ONE - sq_r),
    .root    (sg_root)
  );

  assign sgc = $signed({{(QW-31){1'b0}}, sg_root});

  gca_delay #(.W(QW), .D(D_CGC)) u_cgc_dly (
    .clk(clk),
    .en (en),
    .d  (cgc_r),
    .q  (cgc_d)
  );

  gca_atan2 #(.STAGES(CORDIC_STAGES)) u_arc (
    .clk    (clk),
    .en     (en),
    .y_i    (sgc),
    .x_i    (cgc_d),
    .angle_o(gc_t)
  );

  gca_atan2 #(.STAGES(CORDIC_STAGES)) u_az (
    .clk    (clk),
    .en     (en),
    .y_i    (ya_r),
    .x_i    (xa_r),
    .angle_o(az_t)
  );

  gca_atan2 #(.STAGES(CORDIC_STAGES)) u_baz (
    .clk    (clk),
    .en     (en),
    .y_i    (yb_r),
    .x_i    (xb_r),
    .angle_o(baz_t)
  );

  gca_delay #(.W(128), .D(D_AZ)) u_az_dly (
    .clk(clk),
    .en (en),
    .d  ({az_t, baz_t}),
    .q  ({az_d, baz_d})
  );

  gca_delay #(.W(1), .D(LA)) u_deg_dly (
    .clk(clk),
    .en (en),
    .d  (sg_root == '0),
    .q  (deg_d)
  );

  gca_delay #(.W(1), .D(TA)) u_last_dly (
    .clk(clk),
    .en (en),
    .d  (in_tlast),
    .q  (last_d)
  );

  // Output register: round to the angle width, drop azimuths when degenerate
  always_ff @(posedge clk) begin
    if (en) begin
      pay_r[AB-1:0]      <= to_out(gc_t);
      pay_r[2*AB-1:AB]   <= deg_d ? '0 : to_out(az_d);
      pay_r[3*AB-1:2*AB] <= deg_d ? '0 : to_out(baz_d);
      deg_r              <= deg_d;
      last_r             <= last_d;
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = OUT_DW'(pay_r);
  assign out_tuser  = deg_r;
  assign out_tlast  = last_r;

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (pay_r[3*AB-1:AB] == '0))
    else $error("degenerate result carries a nonzero azimuth");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(vld_r))
    else $error("pipeline moved while the output was stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result presented right after reset");

endmodule
`default_nettype wire

// ----- rtl/gca_delay.sv -----
// Enabled register delay line for side data that rides along the pipeline.
// No package dependency.
`default_nettype none
module gca_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] pipe_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= d;
      for (int i = 1; i < D; i++) begin
        pipe_r[i] <= pipe_r[i-1];
      end
    end
  end

  assign q = pipe_r[D-1];

endmodule
`default_nettype wire

// ----- rtl/gca_sincos.sv -----
// Pipelined rotation CORDIC: sine and cosine of a 64-bit turn angle.
// Uses gca_pkg for widths, gain and the arctangent table.
`default_nettype none
module gca_sincos #(
  parameter int STAGES = 30
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [63:0]                  angle,
  output logic signed [gca_pkg::QW-1:0]     sin_o,
  output logic signed [gca_pkg::QW-1:0]     cos_o
);
  import gca_pkg::*;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic signed [QW-1:0] x_r [STAGES+1];
  logic signed [QW-1:0] y_r [STAGES+1];
  logic signed [63:0]   z_r [STAGES+1];
  logic [1:0]           q_r [STAGES+1];
  logic signed [QW-1:0] sin_r;
  logic signed [QW-1:0] cos_r;

  // Fold into +-eighth turn around the nearest quadrant axis
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CGAIN;
      y_r[0] <= '0;
      z_r[0] <= 64'($signed(angle[61:0]));
      q_r[0] <= angle[63:62] + {1'b0, angle[61]};
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam logic signed [63:0] ROM_I = atan_entry(i);
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1] <= q_r[i];
        if (!z_r[i][63]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ROM_I;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ROM_I;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (q_r[STAGES])
        QUAD_0: begin
          cos_r <= x_r[STAGES];
          sin_r <= y_r[STAGES];
        end
        QUAD_1: begin
          cos_r <= -y_r[STAGES];
          sin_r <= x_r[STAGES];
        end
        QUAD_2: begin
          cos_r <= -x_r[STAGES];
          sin_r <= -y_r[STAGES];
        end
        QUAD_3: begin
          cos_r <= y_r[STAGES];
          sin_r <= -x_r[STAGES];
        end
        default: begin
          cos_r <= x_r[STAGES];
          sin_r <= y_r[STAGES];
        end
      endcase
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule
`default_nettype wire

// ----- rtl/gca_atan2.sv -----
// Pipelined vectoring CORDIC: atan2(y, x) as a 64-bit turn angle.
// Uses gca_pkg for widths and the arctangent table.
`default_nettype none
module gca_atan2 #(
  parameter int STAGES = 30
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [gca_pkg::QW-1:0] y_i,
  input  wire logic signed [gca_pkg::QW-1:0] x_i,
  output logic [63:0]                        angle_o
);
  import gca_pkg::*;

  localparam logic [1:0] QTR_0 = 2'd0;
  localparam logic [1:0] QTR_1 = 2'd1;
  localparam logic [1:0] QTR_3 = 2'd3;

  logic signed [VW-1:0] yw, xw, ys, xs;
  logic [1:0]           bq;
  logic signed [VW-1:0] x_r [STAGES+1];
  logic signed [VW-1:0] y_r [STAGES+1];
  logic signed [63:0]   z_r [STAGES+1];
  logic [1:0]           bq_r [STAGES+1];
  logic                 zero_r [STAGES+1];
  logic [63:0]          angle_r;

  // Rotate the left half plane by a quarter turn
  always_comb begin
    yw = VW'(y_i);
    xw = VW'(x_i);
    if (xw[VW-1]) begin
      if (!yw[VW-1]) begin
        ys = -xw;
        xs = yw;
        bq = QTR_1;
      end else begin
        ys = xw;
        xs = -yw;
        bq = QTR_3;
      end
    end else begin
      ys = yw;
      xs = xw;
      bq = QTR_0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= xs;
      y_r[0]    <= ys;
      z_r[0]    <= '0;
      bq_r[0]   <= bq;
      zero_r[0] <= (ys == '0);
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam logic signed [63:0] ROM_I = atan_entry(i);
    always_ff @(posedge clk) begin
      if (en) begin
        bq_r[i+1]   <= bq_r[i];
        zero_r[i+1] <= zero_r[i];
        if (!y_r[i][VW-1] && (y_r[i] != '0)) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ROM_I;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ROM_I;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_r[STAGES]) angle_r <= '0;
      else angle_r <= {bq_r[STAGES], 62'd0} + z_r[STAGES];
    end
  end

  assign angle_o = angle_r;

endmodule
`default_nettype wire

// ----- rtl/gca_sqrt.sv -----
// Pipelined bit-pair square root of a 61-bit radicand, one root bit a stage.
// Uses gca_pkg for the stage count.
`default_nettype none
module gca_sqrt (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [60:0] radicand,
  output logic      [30:0] root
);
  import gca_pkg::*;

  logic [61:0] v_r [SQ_STEPS];
  logic [61:0] r_r [SQ_STEPS];

  for (genvar s = 0; s < SQ_STEPS; s++) begin : g_step
    localparam logic [61:0] BIT = 62'd1 << (2 * (SQ_STEPS - 1 - s));
    logic [61:0] vi, ri, trial;
    if (s == 0) begin : g_first
      assign vi = {1'b0, radicand};
      assign ri = '0;
    end else begin : g_next
      assign vi = v_r[s-1];
      assign ri = r_r[s-1];
    end
    assign trial = ri + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (vi >= trial) begin
          v_r[s] <= vi - trial;
          r_r[s] <= (ri >> 1) + BIT;
        end else begin
          v_r[s] <= vi;
          r_r[s] <= ri >> 1;
        end
      end
    end
  end

  assign root = r_r[SQ_STEPS-1][30:0];

endmodule
`default_nettype wire
